[hw/rtl/bspc_pkg.sv]
// Shared types and constants for the bounded stack with palindrome check.
// Used by the top level and the port checker.
package bspc_pkg;

	localparam int STACK_DEPTH = 8;
	localparam int WORD_W      = 32;

	// request kinds carried on s_tuser
	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_DISP  = 2'd2,
		MODE_CHECK = 2'd3
	} mode_t;

	// result status carried in m_tuser[1:0]
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
	localparam logic [1:0] STAT_UNUSED    = 2'd3;

	// pending single result
	typedef struct packed {
		logic [1:0] status;
		logic       pal;
		logic       use_rd;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ONE  = 4'b0010,
		S_DISP = 4'b0100,
		S_PAL  = 4'b1000
	} state_t;

endpackage

[hw/rtl/bounded_stack_with_palindrome_check_top.sv]
// Bounded LIFO stack of signed 32-bit words with display and palindrome check.
// Depends on bspc_pkg and bspc_ram (two mirrored copies of the stack storage).
//
// One request is taken at a time on the s_ side; s_tuser carries the mode
// (push, pop, display, check) and s_tdata the word to push. Push, pop and any
// request on an empty stack give one result item. Display of N stored words
// gives N items, top word first, tlast on the bottom word. The palindrome check
// compares words from both ends inward, one pair at a time, and stops at the
// first mismatch; it gives one item. Storage read data is registered, and
// back-pressure on m_tready holds each item. A finished result sits in an
// output register, so a new request can be accepted while it waits.
// Storage has no reset; only words below the fill count are ever read.
module bounded_stack_with_palindrome_check_top #(
	parameter int DEPTH = bspc_pkg::STACK_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bspc_pkg::WORD_W-1:0] s_tdata,  // [31:0] push_value
	input  logic [1:0]                  s_tuser,  // [1:0] mode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bspc_pkg::WORD_W-1:0] m_tdata,  // [31:0] data_word
	output logic [2:0]                  m_tuser,  // [1:0] status, [2] is_palindrome
	output logic                        m_tlast
);

	import bspc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	state_t         state_q, state_d;
	logic [CW-1:0]  fill_q, fill_d;
	logic [AW-1:0]  lo_q, lo_d, hi_q, hi_d;
	res_t           res_q, res_d;

	logic              we;
	logic              re_a, re_b;
	logic [AW-1:0]     ra_a, ra_b, top_addr;
	logic [WORD_W-1:0] rd_a, rd_b;
	logic              full, empty, out_free;

	logic              load;
	logic [WORD_W-1:0] ld_data;
	logic [1:0]        ld_stat;
	logic              ld_pal, ld_last;

	logic              m_tvalid_q;
	logic [WORD_W-1:0] m_tdata_q;
	logic [2:0]        m_tuser_q;
	logic              m_tlast_q;

	mode_t in_mode;

	assign in_mode  = mode_t'(s_tuser);
	assign full     = (fill_q == CW'(DEPTH));
	assign empty    = (fill_q == '0);
	assign top_addr = AW'(fill_q - CW'(1));
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	bspc_ram #(.Width(WORD_W), .Depth(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(fill_q)),
		.wdata (s_tdata),
		.re    (re_a),
		.raddr (ra_a),
		.rdata (rd_a)
	);

	bspc_ram #(.Width(WORD_W), .Depth(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(fill_q)),
		.wdata (s_tdata),
		.re    (re_b),
		.raddr (ra_b),
		.rdata (rd_b)
	);

	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		res_d   = res_q;
		we      = 1'b0;
		re_a    = 1'b0;
		re_b    = 1'b0;
		ra_a    = '0;
		ra_b    = '0;
		load    = 1'b0;
		ld_data = '0;
		ld_stat = STAT_OK;
		ld_pal  = 1'b0;
		ld_last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_ONE;
					case (in_mode)
						MODE_PUSH: begin
							if (full) begin
								res_d = '{status: STAT_OVERFLOW, pal: 1'b0, use_rd: 1'b0};
							end else begin
								we     = 1'b1;
								fill_d = fill_q + CW'(1);
								res_d  = '{status: STAT_OK, pal: 1'b0, use_rd: 1'b0};
							end
						end
						MODE_POP: begin
							if (empty) begin
								res_d = '{status: STAT_UNDERFLOW, pal: 1'b0, use_rd: 1'b0};
							end else begin
								re_a   = 1'b1;
								ra_a   = top_addr;
								fill_d = fill_q - CW'(1);
								res_d  = '{status: STAT_OK, pal: 1'b0, use_rd: 1'b1};
							end
						end
						MODE_DISP: begin
							if (empty) begin
								res_d = '{status: STAT_UNDERFLOW, pal: 1'b0, use_rd: 1'b0};
							end else begin
								re_a    = 1'b1;
								ra_a    = top_addr;
								hi_d    = top_addr;
								state_d = S_DISP;
							end
						end
						default: begin
							if (fill_q <= CW'(1)) begin
								res_d = '{status: STAT_OK, pal: 1'b1, use_rd: 1'b0};
							end else begin
								re_a    = 1'b1;
								re_b    = 1'b1;
								ra_a    = '0;
								ra_b    = top_addr;
								lo_d    = '0;
								hi_d    = top_addr;
								state_d = S_PAL;
							end
						end
					endcase
				end
			end
			S_ONE: begin
				if (out_free) begin
					load    = 1'b1;
					ld_data = res_q.use_rd ? rd_a : '0;
					ld_stat = res_q.status;
					ld_pal  = res_q.pal;
					state_d = S_IDLE;
				end
			end
			S_DISP: begin
				// emit one word per cycle while the output is free, read the next one below it
				if (out_free) begin
					load    = 1'b1;
					ld_data = rd_a;
					ld_last = (hi_q == '0);
					if (hi_q == '0) begin
						state_d = S_IDLE;
					end else begin
						re_a = 1'b1;
						ra_a = hi_q - AW'(1);
						hi_d = hi_q - AW'(1);
					end
				end
			end
			S_PAL: begin
				if (rd_a != rd_b) begin
					res_d   = '{status: STAT_OK, pal: 1'b0, use_rd: 1'b0};
					state_d = S_ONE;
				end else if (({1'b0, lo_q} + (AW+1)'(2)) < {1'b0, hi_q}) begin
					// next pair still lies strictly inside
					re_a = 1'b1;
					re_b = 1'b1;
					ra_a = lo_q + AW'(1);
					ra_b = hi_q - AW'(1);
					lo_d = lo_q + AW'(1);
					hi_d = hi_q - AW'(1);
				end else begin
					res_d   = '{status: STAT_OK, pal: 1'b1, use_rd: 1'b0};
					state_d = S_ONE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		res_q <= res_d;
		if (load) begin
			m_tdata_q <= ld_data;
			m_tuser_q <= {ld_pal, ld_stat};
			m_tlast_q <= ld_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

[hw/rtl/bspc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bspc_ram #(
	parameter  int Width = 32,
	parameter  int Depth = 8,
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data while no read is issued
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/bspc_checker.sv]
// Port-level checks for the bounded stack top level, attached by bind.
// Depends on bspc_pkg for the status codes.
module bspc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);

	import bspc_pkg::*;

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result item changed while stalled");

	// errors end their request at once
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != STAT_OK |-> m_tlast && m_tdata == '0)
		else $error("error result not a single zero item");

	// palindrome flag comes only on a clean single item with no data
	a_pal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == STAT_OK && m_tdata == '0 && m_tlast)
		else $error("palindrome flag on a malformed item");

	a_stat_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[1:0] != STAT_UNUSED)
		else $error("unused status code on result item");

endmodule

bind bounded_stack_with_palindrome_check_top bspc_checker u_bspc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
